@@ rtl/core/ral_pkg.sv @@
`default_nettype none

package ral_pkg;

  // fixed field widths of the request and response words
  localparam int ACT_W     = 3;
  localparam int POS_W     = 8;
  localparam int ITEM_W    = 64;
  localparam int CNT_OUT_W = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_READ    = 3'd3,
    ACT_COUNT   = 3'd4,
    ACT_CLEAR   = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BADRANK = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAPT,
    S_SHIFT,
    S_PUT,
    S_DONE
  } seq_e;

  typedef struct packed {
    status_e               status;
    logic [ITEM_W-1:0]     item;
    logic [CNT_OUT_W-1:0]  count;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/ral_ram.sv @@
`default_nettype none

module ral_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ral_seq.sv @@
`default_nettype none

module ral_seq import ral_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int ELEM_WIDTH = 64,
  localparam int AW        = $clog2(CAPACITY),
  localparam int CW        = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [ACT_W-1:0]      action_i,
  input  wire logic [POS_W-1:0]      position_i,
  input  wire logic [ITEM_W-1:0]     item_in_i,
  output logic                       res_valid_o,
  input  wire logic                  res_take_i,
  output res_t                       res_o,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [ELEM_WIDTH-1:0]      ram_wdata_o,
  output logic                       ram_re_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  wire logic [ELEM_WIDTH-1:0] ram_rdata_i
);

  // compare width wide enough for both the rank and the count
  localparam int KW = (CW > POS_W) ? CW : POS_W;

  seq_e                  state_q, state_d;
  act_e                  act_q, act_d;
  act_e                  act_in;
  status_e               st_q, st_d;
  logic [AW-1:0]         rank_q, rank_d;
  logic [ELEM_WIDTH-1:0] item_q, item_d;
  logic [ELEM_WIDTH-1:0] res_q, res_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         left_q, left_d;
  logic [AW-1:0]         src_q, src_d;
  logic [AW-1:0]         dst_q, dst_d;
  logic                  pend_q, pend_d;
  logic [KW-1:0]         pos_k, cnt_k;
  logic                  full, empty, accept;

  assign act_in = act_e'(action_i);
  assign pos_k  = KW'(position_i);
  assign cnt_k  = KW'(cnt_q);
  assign full   = (cnt_q == CW'(CAPACITY));
  assign empty  = (cnt_q == '0);
  assign accept = in_valid_i && (state_q == S_IDLE);

  assign in_stall_o   = (state_q != S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.status = st_q;
  assign res_o.item   = ITEM_W'(res_q);
  assign res_o.count  = CNT_OUT_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    st_q   <= st_d;
    rank_q <= rank_d;
    item_q <= item_d;
    res_q  <= res_d;
    left_q <= left_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    st_d        = st_q;
    rank_d      = rank_q;
    item_d      = item_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    src_d       = src_q;
    dst_d       = dst_q;
    pend_d      = pend_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = dst_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = src_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = act_in;
          rank_d  = AW'(position_i);
          item_d  = item_in_i[ELEM_WIDTH-1:0];
          res_d   = '0;
          st_d    = ST_OK;
          state_d = S_DONE;
          unique case (act_in) inside
            ACT_INSERT: begin
              if (pos_k > cnt_k) begin
                st_d = ST_BADRANK;
              end else if (full) begin
                st_d = ST_FULL;
              end else if (pos_k == cnt_k) begin
                state_d = S_PUT;
              end else begin
                left_d  = CW'(cnt_k - pos_k);
                src_d   = AW'(cnt_q - CW'(1));
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            ACT_REMOVE, ACT_REPLACE, ACT_READ: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else if (pos_k >= cnt_k) begin
                st_d = ST_BADRANK;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = AW'(position_i);
                state_d     = S_CAPT;
              end
            end
            ACT_COUNT: st_d = ST_OK;
            ACT_CLEAR: cnt_d = '0;
            default: st_d = ST_OK;
          endcase
        end
      end

      S_CAPT: begin
        res_d   = ram_rdata_i;
        state_d = S_DONE;
        if (act_q == ACT_REPLACE) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = rank_q;
          ram_wdata_o = item_q;
        end else if (act_q == ACT_REMOVE) begin
          cnt_d  = cnt_q - CW'(1);
          left_d = cnt_q - CW'(1) - CW'(rank_q);
          if (left_d != '0) begin
            src_d   = rank_q + AW'(1);
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end
        end
      end

      // one entry read and one written back per cycle
      S_SHIFT: begin
        if (pend_q) begin
          ram_we_o = 1'b1;
        end
        if (left_q != '0) begin
          ram_re_o = 1'b1;
          left_d   = left_q - CW'(1);
          pend_d   = 1'b1;
          if (act_q == ACT_INSERT) begin
            dst_d = src_q + AW'(1);
            src_d = src_q - AW'(1);
          end else begin
            dst_d = src_q - AW'(1);
            src_d = src_q + AW'(1);
          end
        end else begin
          pend_d  = 1'b0;
          state_d = (act_q == ACT_INSERT) ? S_PUT : S_DONE;
        end
      end

      S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = rank_q;
        ram_wdata_o = item_q;
        cnt_d       = cnt_q + CW'(1);
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !ram_we_o)
    else $error("memory write outside an operation");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we_o && ram_re_o) |-> (ram_waddr_o != ram_raddr_o))
    else $error("read and write hit the same entry");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted word did not start an operation");

  a_shift_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && left_q == '0) |-> pend_q)
    else $error("shift ended without a pending write");

endmodule

`default_nettype wire

@@ rtl/core/ranked_array_list.sv @@
// ranked array list of CAPACITY entries of ELEM_WIDTH bits each. every request word
// (insert, remove, replace, read, count, clear at a zero-based rank) gives exactly one
// response word with a status, the removed/old/read element and the new entry count.
// entries live in a simple dual-port memory with registered read; insert and remove
// move the later entries one memory read and one write per cycle, so the shift is the
// cost. the sequencer takes one request at a time and stalls the input until it is done
// with it, so a long shift holds back the next request. responses sit in an output
// register, so the next request can be taken while a response waits; while that register
// holds a word that is not yet taken, a finished request waits in the sequencer, so a
// stalled output holds the engine for as long as the stall lasts. no clearing pass after
// reset: the memory is only read at ranks below the count, which are always written

`default_nettype none

module ranked_array_list import ral_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int ELEM_WIDTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request words
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ACT_W-1:0]     action_i,
  input  wire logic [POS_W-1:0]     position_i,
  input  wire logic [ITEM_W-1:0]    item_in_i,
  // response words
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                status_o,
  output logic [ITEM_W-1:0]         item_out_o,
  output logic [CNT_OUT_W-1:0]      count_out_o
);

  localparam int AW = $clog2(CAPACITY);

  // sequencer to memory
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  // sequencer to output register
  res_t res;
  logic res_valid;
  logic res_take;

  // output register
  logic ovld_q, ovld_d;
  res_t ores_q, ores_d;

  ral_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ral_seq #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .position_i  (position_i),
    .item_in_i   (item_in_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // the output slot frees when empty or when its word leaves this cycle
  assign res_take = !ovld_q || !out_stall_i;

  always_comb begin
    ovld_d = ovld_q;
    ores_d = ores_q;
    if (res_take) begin
      ovld_d = res_valid;
      if (res_valid) begin
        ores_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ores_q <= ores_d;
  end

  assign out_valid_o = ovld_q;
  assign status_o    = ores_q.status;
  assign item_out_o  = ores_q.item;
  assign count_out_o = ores_q.count;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ral_pkg::*;

  // list geometry, kept at the block defaults
  localparam int LIST_CAP = 256;
  localparam int ELEM_W = 64;
  localparam logic [ITEM_W-1:0] ELEM_MASK = {ITEM_W{1'b1}} >> (ITEM_W - ELEM_W);

  // action codes that the block ignores
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int RAND_ITEMS = 750;
  localparam int IDLE_PCT = 19;
  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;

  // one request word as the driver sees it
  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item;
  } request_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // request side
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [ACT_W-1:0]     req_action = '0;
  logic [POS_W-1:0]     req_position = '0;
  logic [ITEM_W-1:0]    req_item = '0;

  // response side
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [1:0]           rsp_status;
  logic [ITEM_W-1:0]    rsp_item;
  logic [CNT_OUT_W-1:0] rsp_count;

  // words still to send and responses still owed
  request_t  send_q[$];
  res_t      owed_q[$];
  request_t  next_word;
  res_t      want;

  // shadow copy of the list that the predictor keeps
  logic [ITEM_W-1:0] shadow_mem [LIST_CAP];
  int unsigned       shadow_len = 0;
  int unsigned       peak_len = 0;
  int unsigned       status_hits [4] = '{0, 0, 0, 0};

  // length as the stimulus generator expects it, used to aim ranks
  int unsigned gen_len = 0;

  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;

  // a stretch of the run where neither side idles
  logic calm;
  assign calm = (words_in >= 300) && (words_in < 420);

  ranked_array_list #(
    .CAPACITY  (LIST_CAP),
    .ELEM_WIDTH(ELEM_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .action_i   (req_action),
    .position_i (req_position),
    .item_in_i  (req_item),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .status_o   (rsp_status),
    .item_out_o (rsp_item),
    .count_out_o(rsp_count)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // predictor: apply one request to the shadow list and return its response
  function automatic res_t list_apply(logic [ACT_W-1:0] action, logic [POS_W-1:0] rank,
                                      logic [ITEM_W-1:0] item);
    res_t        r;
    int unsigned i;
    r.status = ST_OK;
    r.item = '0;
    item = item & ELEM_MASK;
    case (action)
      ACT_INSERT: begin
        // rank check comes before the full check
        if (rank > shadow_len) r.status = ST_BADRANK;
        else if (shadow_len >= LIST_CAP) r.status = ST_FULL;
        else begin
          for (i = shadow_len; i > rank; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[rank] = item;
          shadow_len++;
        end
      end
      ACT_REMOVE, ACT_REPLACE, ACT_READ: begin
        // empty list wins over a bad rank
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (rank >= shadow_len) r.status = ST_BADRANK;
        else begin
          r.item = shadow_mem[rank];
          if (action == ACT_REMOVE) begin
            for (i = rank; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
            shadow_len--;
          end else if (action == ACT_REPLACE) begin
            shadow_mem[rank] = item;
          end
        end
      end
      ACT_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.item = r.item & ELEM_MASK;
    r.count = shadow_len[CNT_OUT_W-1:0];
    if (shadow_len > peak_len) peak_len = shadow_len;
    status_hits[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ITEM_W-1:0] got, logic [ITEM_W-1:0] exp);
    if (fail_cnt < MAX_REPORTS)
      $display("mismatch on response %0d: %s got 0x%0h expected 0x%0h",
               words_out, what, got, exp);
    fail_cnt++;
  endtask

  // queue a request and track the length it leaves behind
  task automatic send_word(logic [ACT_W-1:0] action, logic [POS_W-1:0] rank,
                           logic [ITEM_W-1:0] item);
    request_t w;
    w.action = action;
    w.position = rank;
    w.item = item;
    send_q.push_back(w);
    case (action)
      ACT_INSERT: if (rank <= gen_len && gen_len < LIST_CAP) gen_len++;
      ACT_REMOVE: if (gen_len > 0 && rank < gen_len) gen_len--;
      ACT_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  // element words with the all-zero and all-one extremes mixed in
  function automatic logic [ITEM_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // a rank below span, or anything when the span is empty
  function automatic logic [POS_W-1:0] live_rank(int unsigned span);
    int unsigned top;
    if (span == 0) return POS_W'($urandom_range(0, 255));
    top = (span - 1 > 255) ? 255 : span - 1;
    return POS_W'($urandom_range(0, top));
  endfunction

  // driver: log the word taken at this edge, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        owed_q.push_back(list_apply(req_action, req_position, req_item));
        words_in <= words_in + 1;
      end
      // a stalled word stays put
      if (!req_valid || !req_stall) begin
        if (send_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_word = send_q.pop_front();
          req_action <= next_word.action;
          req_position <= next_word.position;
          req_item <= next_word.item;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each response word taken at this edge against the oldest owed one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_q.size() == 0) begin
          report_mismatch("unexpected response, status", ITEM_W'(rsp_status), '0);
        end else begin
          want = owed_q.pop_front();
          if (rsp_status !== want.status)
            report_mismatch("status", ITEM_W'(rsp_status), ITEM_W'(want.status));
          if (rsp_item !== want.item)
            report_mismatch("item", rsp_item, want.item);
          if (rsp_count !== want.count)
            report_mismatch("count", ITEM_W'(rsp_count), ITEM_W'(want.count));
        end
        words_out <= words_out + 1;
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned      made;
    int unsigned      fills;
    int unsigned      roll;
    int unsigned      burst;
    int unsigned      lo;
    int unsigned      k;
    logic [ACT_W-1:0] act;

    // directed: empty list, rank edges, front/middle/end inserts, spare codes
    send_word(ACT_READ, 8'd0, '0);
    send_word(ACT_REMOVE, 8'd255, '0);
    send_word(ACT_REPLACE, 8'd0, '1);
    send_word(ACT_INSERT, 8'd1, '1);
    send_word(ACT_INSERT, 8'd0, '1);
    send_word(ACT_INSERT, 8'd1, '0);
    send_word(ACT_INSERT, 8'd0, 64'hA5A5_A5A5_A5A5_A5A5);
    send_word(ACT_INSERT, 8'd1, 64'h5A5A_5A5A_5A5A_5A5A);
    send_word(ACT_READ, 8'd3, '0);
    send_word(ACT_READ, 8'd4, '0);
    send_word(ACT_READ, 8'd255, '0);
    send_word(ACT_REPLACE, 8'd0, 64'h8000_0000_0000_0001);
    send_word(ACT_REMOVE, 8'd1, '0);
    send_word(ACT_REMOVE, 8'd2, '0);
    send_word(ACT_INSERT, 8'd255, '1);
    send_word(ACT_COUNT, 8'd255, '1);
    send_word(ACT_SPARE_LO, 8'd0, '1);
    send_word(ACT_SPARE_HI, 8'd255, '1);
    send_word(ACT_REMOVE, 8'd0, '0);
    send_word(ACT_CLEAR, 8'd0, '0);
    send_word(ACT_COUNT, 8'd0, '0);
    send_word(ACT_INSERT, 8'd0, {$urandom(), $urandom()});
    send_word(ACT_CLEAR, 8'd7, '0);
    send_word(ACT_READ, 8'd0, '0);

    // random episodes: mostly legal bursts, a little noise, two runs up to full
    made = 0;
    fills = 0;
    while (made < RAND_ITEMS) begin
      if ((fills == 0 && made > 150) || (fills == 1 && made > 500)) begin
        fills++;
        while (gen_len < LIST_CAP) begin
          send_word(ACT_INSERT, $urandom_range(0, 1) ? POS_W'(gen_len) : live_rank(gen_len + 1),
                    pick_word());
          made++;
        end
        // inserts at capacity, then the top rank
        repeat (3) send_word(ACT_INSERT, POS_W'($urandom_range(0, 255)), pick_word());
        send_word(ACT_READ, 8'd255, '0);
        send_word(ACT_REPLACE, 8'd255, pick_word());
        send_word(ACT_REMOVE, 8'd255, '0);
        made += 6;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_word(ACT_CLEAR, POS_W'($urandom_range(0, 255)), pick_word());
          made++;
        end else if (roll < 16) begin
          // noise: any code, any rank
          burst = $urandom_range(1, 6);
          for (k = 0; k < burst; k++) begin
            act = ACT_W'($urandom_range(0, 7));
            send_word(act, POS_W'($urandom_range(0, 255)), pick_word());
            if (act <= ACT_CLEAR) made++;
          end
        end else begin
          burst = $urandom_range(4, 16);
          for (k = 0; k < burst; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
              // rank just past the end or beyond
              act = ACT_W'($urandom_range(ACT_INSERT, ACT_READ));
              lo = (act == ACT_INSERT) ? gen_len + 1 : gen_len;
              send_word(act, (lo <= 255) ? POS_W'($urandom_range(lo, 255)) : live_rank(gen_len),
                        pick_word());
            end else if (roll < 40) begin
              send_word(ACT_INSERT, live_rank(gen_len + 1), pick_word());
            end else if (roll < 65) begin
              send_word(ACT_REMOVE, live_rank(gen_len), pick_word());
            end else if (roll < 80) begin
              send_word(ACT_REPLACE, live_rank(gen_len), pick_word());
            end else if (roll < 95) begin
              send_word(ACT_READ, live_rank(gen_len), pick_word());
            end else begin
              send_word(ACT_COUNT, POS_W'($urandom_range(0, 255)), pick_word());
            end
            made++;
          end
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain, then give a worst-case shift time for stray responses
    while (send_q.size() != 0 || req_valid || owed_q.size() != 0) @(negedge clk_i);
    repeat (LIST_CAP + 16) @(negedge clk_i);

    $display("run: %0d requests sent, %0d responses checked, list peaked at %0d entries",
             words_in, words_out, peak_len);
    $display("status mix: ok %0d, full %0d, empty %0d, bad rank %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_BADRANK]);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ral_pkg.sv
rtl/core/ral_ram.sv
rtl/core/ral_seq.sv
rtl/core/ranked_array_list.sv
test/tb.sv
